/* hw/rtl/uf_pkg.sv */
package uf_pkg;

    localparam int NODE_W = 16;
    localparam int NODES  = 1 << NODE_W;
    localparam int CNT_W  = NODE_W + 1;

    localparam logic [1:0] CMD_UNION = 2'd0;
    localparam logic [1:0] CMD_FIND  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(NODES);

    typedef logic [NODE_W-1:0] node_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_CHK_P,
        ST_CHK_G,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        V_HOLD,
        V_A,
        V_B,
        V_DATA
    } v_sel_t;

    typedef enum logic {
        RD_V,
        RD_DATA
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SWEEP,
        WR_HALVE,
        WR_LINK
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        v_sel_t  v_sel;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    start_b;
        logic    set_err;
        logic    set_root;
        logic    set_merged;
        logic    sweep_rst;
        logic    emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       a_err;
        logic       b_err;
        logic       at_root;
        logic       second;
        logic       roots_differ;
        logic       sweep_last;
        logic       out_free;
    } dp_sts_t;

endpackage

/* hw/rtl/uf_req_if.sv */
interface uf_req_if;
    import uf_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    node_t      node_a;
    node_t      node_b;

    modport source (output valid, output cmd, output node_a, output node_b, input ready);
    modport sink   (input valid, input cmd, input node_a, input node_b, output ready);
endinterface

/* hw/rtl/uf_rsp_if.sv */
interface uf_rsp_if;
    import uf_pkg::*;

    logic  valid;
    logic  ready;
    node_t root;
    logic  merged;
    logic  range_error;

    modport source (output valid, output root, output merged, output range_error, input ready);
    modport sink   (input valid, input root, input merged, input range_error, output ready);
endinterface

/* hw/rtl/uf_ctrl.sv */
module uf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  uf_pkg::dp_sts_t sts,
    output uf_pkg::dp_cmd_t cmd
);
    import uf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.cmd)
                    CMD_UNION: state_next = (sts.a_err || sts.b_err) ? ST_FINISH : ST_READ;
                    CMD_FIND:  state_next = sts.a_err ? ST_FINISH : ST_READ;
                    CMD_CLEAR: state_next = ST_CLEAR;
                    default:   state_next = ST_FINISH;
                endcase
            end
            ST_READ:
            begin
                state_next = ST_CHK_P;
            end
            ST_CHK_P:
            begin
                if (!sts.at_root)
                begin
                    state_next = ST_CHK_G;
                end
                else if (!sts.second && sts.cmd == CMD_UNION)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CHK_G:
            begin
                state_next = ST_CHK_P;
            end
            ST_CLEAR:
            begin
                if (sts.sweep_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.v_sel = V_HOLD;
        cmd.rd_sel = RD_V;
        cmd.wr_sel = WR_NONE;
        req_ready = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.wr_sel = WR_SWEEP;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_DECODE:
            begin
                cmd.v_sel     = V_A;
                cmd.sweep_rst = 1'b1;
                case (sts.cmd)
                    CMD_UNION: cmd.set_err = sts.a_err || sts.b_err;
                    CMD_FIND:  cmd.set_err = sts.a_err;
                    default:   cmd.set_err = 1'b0;
                endcase
            end
            ST_READ:
            begin
                cmd.rd_sel = RD_V;
            end
            ST_CHK_P:
            begin
                if (!sts.at_root)
                begin
                    cmd.rd_sel = RD_DATA;
                end
                else if (!sts.second && sts.cmd == CMD_UNION)
                begin
                    cmd.start_b = 1'b1;
                    cmd.v_sel   = V_B;
                end
                else
                begin
                    cmd.set_root = 1'b1;
                    if (sts.second && sts.roots_differ)
                    begin
                        cmd.wr_sel     = WR_LINK;
                        cmd.set_merged = 1'b1;
                    end
                end
            end
            ST_CHK_G:
            begin
                cmd.wr_sel = WR_HALVE;
                cmd.v_sel  = V_DATA;
                cmd.rd_sel = RD_DATA;
            end
            ST_CLEAR:
            begin
                cmd.wr_sel = WR_SWEEP;
            end
            ST_FINISH:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/uf_dp.sv */
module uf_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [uf_pkg::CNT_W-1:0] cfg_wdata,
    input  logic [1:0]               in_cmd,
    input  uf_pkg::node_t            in_a,
    input  uf_pkg::node_t            in_b,
    input  uf_pkg::dp_cmd_t          cmd,
    output uf_pkg::dp_sts_t          sts,
    output logic                     out_valid,
    input  logic                     out_ready,
    output uf_pkg::node_t            out_root,
    output logic                     out_merged,
    output logic                     out_err
);
    import uf_pkg::*;

    node_t mem [NODES];

    logic [CNT_W-1:0] node_count_reg;
    logic [1:0]       cmd_reg;
    node_t            a_reg;
    node_t            b_reg;
    node_t            v_reg;
    node_t            v_next;
    node_t            ra_reg;
    node_t            rd_data_reg;
    node_t            sweep_reg;
    logic             second_reg;
    node_t            res_root_reg;
    logic             res_merged_reg;
    logic             res_err_reg;
    logic             out_valid_reg;
    node_t            out_root_reg;
    logic             out_merged_reg;
    logic             out_err_reg;

    node_t rd_addr;
    node_t wr_addr;
    node_t wr_data;
    logic  wr_en;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_DATA: rd_addr = rd_data_reg;
            default: rd_addr = v_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = sweep_reg;
        wr_data = sweep_reg;
        case (cmd.wr_sel)
            WR_SWEEP:
            begin
                wr_addr = sweep_reg;
                wr_data = sweep_reg;
            end
            WR_HALVE:
            begin
                wr_addr = v_reg;
                wr_data = rd_data_reg;
            end
            WR_LINK:
            begin
                wr_addr = ra_reg;
                wr_data = v_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.v_sel)
            V_A:     v_next = a_reg;
            V_B:     v_next = b_reg;
            V_DATA:  v_next = rd_data_reg;
            default: v_next = v_reg;
        endcase
    end

    // parent table, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= in_cmd;
            a_reg   <= in_a;
            b_reg   <= in_b;
        end
        v_reg <= v_next;
        if (cmd.start_b)
        begin
            ra_reg <= v_reg;
        end
        if (cmd.load)
        begin
            res_root_reg   <= '0;
            res_merged_reg <= 1'b0;
            res_err_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.set_root)
            begin
                res_root_reg <= v_reg;
            end
            if (cmd.set_merged)
            begin
                res_merged_reg <= 1'b1;
            end
            if (cmd.set_err)
            begin
                res_err_reg <= 1'b1;
            end
        end
        if (cmd.emit)
        begin
            out_root_reg   <= res_root_reg;
            out_merged_reg <= res_merged_reg;
            out_err_reg    <= res_err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            sweep_reg      <= '0;
            second_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (cmd.sweep_rst)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.wr_sel == WR_SWEEP)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.load)
            begin
                second_reg <= 1'b0;
            end
            else if (cmd.start_b)
            begin
                second_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.cmd          = cmd_reg;
        sts.a_err        = {1'b0, a_reg} >= node_count_reg;
        sts.b_err        = {1'b0, b_reg} >= node_count_reg;
        sts.at_root      = rd_data_reg == v_reg;
        sts.second       = second_reg;
        sts.roots_differ = ra_reg != v_reg;
        sts.sweep_last   = sweep_reg == '1;
        sts.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_root   = out_root_reg;
    assign out_merged = out_merged_reg;
    assign out_err    = out_err_reg;

endmodule

/* hw/rtl/union_find_engine_core.sv */
// Find and union results reach the result register once the parent hops of each
// operand are walked; clear rewrites the table, one table entry written per cycle.
// One transaction at a time; each hop of the parent table walk (read parent, read
// grandparent, write back) uses the table's one read port and one write port.
// Reset: asynchronous, active low; afterwards a sweep writes every entry to its own
// index with req.ready low. node_count resets to 65536.
module union_find_engine_core (
    input  logic                     clk,
    input  logic                     rst_n,
    uf_req_if.sink                   req,
    uf_rsp_if.source                 rsp,
    input  logic                     cfg_we,
    input  logic [uf_pkg::CNT_W-1:0] cfg_wdata
);
    import uf_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    uf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    uf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_cmd     (req.cmd),
        .in_a       (req.node_a),
        .in_b       (req.node_b),
        .cmd        (dp_cmd),
        .sts        (dp_sts),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_root   (rsp.root),
        .out_merged (rsp.merged),
        .out_err    (rsp.range_error)
    );

endmodule
